// ===== hw/rtl/his_pkg.sv =====
package his_pkg;

	localparam int VALUE_WIDTH    = 32;
	localparam int MAX_BREAKS_DEF = 64;
	localparam int COUNT_W        = 7;
	localparam int INDEX_W        = 6;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	typedef enum logic [0:0] {
		REQ_LOAD   = 1'b0,
		REQ_SEARCH = 1'b1
	} req_type_t;

	typedef struct packed {
		logic                          req_type;
		logic [INDEX_W-1:0]            entry_index;
		logic signed [VALUE_WIDTH-1:0] entry_value;
		logic signed [VALUE_WIDTH-1:0] search_key;
		logic [INDEX_W-1:0]            start_hint;
	} in_word_t;

	typedef struct packed {
		logic [INDEX_W-1:0] bin_index;
		logic               below_range;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HI_RD,
		ST_HI_CMP,
		ST_LO_RD,
		ST_LO_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_BIS_RD,
		ST_BIS_CMP,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_LO,
		RD_HI,
		RD_MID
	} rd_sel_t;

	typedef struct packed {
		logic    load_entry;
		logic    load_search;
		rd_sel_t rd_sel;
		logic    up_adv;
		logic    dn_adv;
		logic    bis_upd;
		logic    set_below;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic ge;
		logic up_end;
		logic lo_zero;
		logic span_gt1;
	} stat_t;

endpackage

// ===== hw/rtl/hinted_interval_search.sv =====
// Interval search over an ascending table of signed break values. A load word
// writes one table entry and is taken with no result. A search word is taken,
// then the block stalls its input until the result is placed in the output
// register. After taking the word it probes the table, each probe a read on
// the single registered read port of the table memory and then a compare:
// one or two probes for the hint interval, up to log2(count) for the gallop
// and up to log2(count) for the bisection. Before each bisection probe it
// checks whether the bracket is down to a single interval; a key below the
// first entry skips that check. It then hands the result over. A waiting
// result does not block the next word; only a second result finished while
// the first is still stalled waits.
module hinted_interval_search import his_pkg::*; #(
	parameter int MAX_BREAKS = MAX_BREAKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_word
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	his_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (in_word.req_type),
		.out_stall   (out_stall),
		.stat        (stat),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	his_dp #(
		.MAX_BREAKS (MAX_BREAKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_word (cfg_word),
		.cmd      (cmd),
		.stat     (stat),
		.out_word (out_word)
	);

endmodule

// ===== hw/rtl/his_dp.sv =====
module his_dp import his_pkg::*; #(
	parameter int MAX_BREAKS = MAX_BREAKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  in_word_t           in_word,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_word,
	input  cmd_t               cmd,
	output stat_t              stat,
	output out_word_t          out_word
);

	localparam int AW = $clog2(MAX_BREAKS);
	localparam int IW = $clog2(MAX_BREAKS + 1);
	localparam int SW = IW + 1;
	localparam int CW = (IW > COUNT_W) ? IW + 1 : COUNT_W + 1;
	localparam int EW = IW + INDEX_W;

	logic [VALUE_WIDTH-1:0] mem [MAX_BREAKS];
	logic [VALUE_WIDTH-1:0] rd_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [COUNT_W-1:0]     count_q;
	logic [IW-1:0]          lo_q, hi_q, n_q;
	logic [SW-1:0]          step_q;
	logic                   below_q;
	out_word_t              out_q;

	logic [CW-1:0] cnt_ext, hint_ext;
	logic [IW-1:0] n_new, nm2, lo_new, mid;
	logic [SW-1:0] up_sum, dn_diff, mid_sum;
	logic          up_end, dn_end;
	logic [EW-1:0] widx_ext, lo_ext;
	logic          widx_ok;
	logic [IW-1:0] raddr_full;
	logic [AW-1:0] raddr, waddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_word;
		end
	end

	always_comb begin
		cnt_ext  = CW'(count_q);
		hint_ext = CW'(in_word.start_hint);
		if (cnt_ext < CW'(2)) begin
			n_new = IW'(2);
		end else if (cnt_ext > CW'(MAX_BREAKS)) begin
			n_new = IW'(MAX_BREAKS);
		end else begin
			n_new = cnt_ext[IW-1:0];
		end
		nm2 = n_new - IW'(2);
		if (hint_ext > CW'(nm2)) begin
			lo_new = nm2;
		end else begin
			lo_new = hint_ext[IW-1:0];
		end
	end

	assign up_sum  = SW'(hi_q) + step_q;
	assign up_end  = up_sum >= SW'(n_q);
	assign dn_diff = SW'(lo_q) - step_q;
	assign dn_end  = SW'(lo_q) <= step_q;
	assign mid_sum = SW'(lo_q) + SW'(hi_q);
	assign mid     = mid_sum[SW-1:1];

	assign stat.ge       = $signed(key_q) >= $signed(rd_q);
	assign stat.up_end   = up_end;
	assign stat.lo_zero  = lo_q == '0;
	assign stat.span_gt1 = SW'(hi_q) > (SW'(lo_q) + SW'(1));

	always_comb begin
		unique case (cmd.rd_sel)
			RD_LO:   raddr_full = lo_q;
			RD_HI:   raddr_full = hi_q;
			default: raddr_full = mid;
		endcase
	end
	assign raddr = raddr_full[AW-1:0];

	assign widx_ext = EW'(in_word.entry_index);
	assign widx_ok  = widx_ext < EW'(MAX_BREAKS);
	assign waddr    = widx_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_entry && widx_ok) begin
			mem[waddr] <= in_word.entry_value;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		priority if (cmd.load_search) begin
			key_q  <= in_word.search_key;
			n_q    <= n_new;
			lo_q   <= lo_new;
			hi_q   <= lo_new + IW'(1);
			step_q <= SW'(1);
		end else if (cmd.up_adv) begin
			lo_q   <= hi_q;
			hi_q   <= up_end ? n_q : up_sum[IW-1:0];
			step_q <= step_q << 1;
		end else if (cmd.dn_adv) begin
			hi_q   <= lo_q;
			lo_q   <= dn_end ? '0 : dn_diff[IW-1:0];
			step_q <= step_q << 1;
		end else if (cmd.bis_upd) begin
			if (stat.ge) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_search) begin
			below_q <= 1'b0;
		end else if (cmd.set_below) begin
			below_q <= 1'b1;
		end
	end

	assign lo_ext = EW'(lo_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.bin_index   <= lo_ext[INDEX_W-1:0];
			out_q.below_range <= below_q;
		end
	end

	assign out_word = out_q;

endmodule

// ===== hw/rtl/his_ctrl.sv =====
module his_ctrl import his_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_req_type,
	input  logic  out_stall,
	input  stat_t stat,
	output logic  in_stall,
	output logic  out_valid,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_full_q;
	logic   accept, can_out;

	assign accept  = in_valid && (state_q == ST_IDLE);
	assign can_out = !out_full_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_full_q <= 1'b1;
			end else if (!out_stall) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_req_type == REQ_SEARCH)) state_d = ST_HI_RD;
			end
			ST_HI_RD:  state_d = ST_HI_CMP;
			ST_HI_CMP: begin
				if (stat.ge) state_d = stat.up_end ? ST_BIS_RD : ST_UP_RD;
				else state_d = ST_LO_RD;
			end
			ST_LO_RD:  state_d = ST_LO_CMP;
			ST_LO_CMP: state_d = stat.ge ? ST_BIS_RD : ST_DN_RD;
			ST_DN_RD:  state_d = ST_DN_CMP;
			ST_DN_CMP: begin
				priority if (stat.ge) state_d = ST_BIS_RD;
				else if (stat.lo_zero) state_d = ST_FIN;
				else state_d = ST_DN_RD;
			end
			ST_UP_RD:  state_d = ST_UP_CMP;
			ST_UP_CMP: begin
				if (stat.ge) state_d = stat.up_end ? ST_BIS_RD : ST_UP_RD;
				else state_d = ST_BIS_RD;
			end
			ST_BIS_RD:  state_d = stat.span_gt1 ? ST_BIS_CMP : ST_FIN;
			ST_BIS_CMP: state_d = ST_BIS_RD;
			ST_FIN: begin
				if (can_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_HI;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_entry  = accept && (in_req_type == REQ_LOAD);
				cmd.load_search = accept && (in_req_type == REQ_SEARCH);
			end
			ST_HI_RD: cmd.rd_sel = RD_HI;
			ST_HI_CMP: cmd.up_adv = stat.ge;
			ST_LO_RD: cmd.rd_sel = RD_LO;
			ST_LO_CMP: cmd.dn_adv = !stat.ge;
			ST_DN_RD: cmd.rd_sel = RD_LO;
			ST_DN_CMP: begin
				cmd.set_below = !stat.ge && stat.lo_zero;
				cmd.dn_adv    = !stat.ge && !stat.lo_zero;
			end
			ST_UP_RD: cmd.rd_sel = RD_HI;
			ST_UP_CMP: cmd.up_adv = stat.ge;
			ST_BIS_RD: cmd.rd_sel = RD_MID;
			ST_BIS_CMP: cmd.bis_upd = 1'b1;
			ST_FIN: cmd.load_out = can_out;
			default: ;
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_full_q;

endmodule

// ===== hw/rtl/his_checker.sv =====
module his_checker import his_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input in_word_t           in_word,
	input logic               out_valid,
	input logic               out_stall,
	input out_word_t          out_word
);

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("out_word changed while stalled");

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_word.req_type == REQ_LOAD) |=> !in_stall)
		else $error("load word left the block busy");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_word.req_type == REQ_SEARCH) |=> in_stall)
		else $error("search word did not start a search");

	a_below_bin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.below_range |-> out_word.bin_index == '0)
		else $error("below_range with nonzero bin_index");

endmodule

bind hinted_interval_search his_checker u_his_checker (.*);
